// File: rtl/core/srs_pkg.sv
`default_nettype none
// ============================================================================
// srs_pkg: shared constants and types for the stratified resampler
// Sizes of the weight store, derived arithmetic widths, request codes,
// register indexes and the sequencer state type.
// ============================================================================
package srs_pkg;

   // Basic sizes.
   localparam int MAX_PARTICLES = 1024;
   localparam int WEIGHT_BITS   = 32;
   localparam int UNIFORM_BITS  = 16;

   // Index into the store, and a count that can also hold MAX_PARTICLES.
   localparam int IDX_W = $clog2(MAX_PARTICLES);
   localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

   // A cumulative sum of MAX_PARTICLES weights never overflows this width.
   localparam int CUM_W = WEIGHT_BITS + IDX_W;

   // Cross-multiplication operands: scale = P << U, threshold = (m << U) + r.
   localparam int SCALE_W = CNT_W + UNIFORM_BITS;
   localparam int THR_W   = IDX_W + UNIFORM_BITS;

   // The cumulative operand is split in two halves for the multipliers.
   localparam int LO_W   = CUM_W / 2;
   localparam int HI_W   = CUM_W - LO_W;
   localparam int PART_W = HI_W + SCALE_W;
   localparam int PROD_W = CUM_W + SCALE_W;

   // Register map of the configuration port.
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam logic REG_PARTICLE_COUNT = 1'b0;
   localparam logic [CNT_W-1:0] PARTICLE_COUNT_RESET = CNT_W'(MAX_PARTICLES);

   // Request codes.
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_DRAW = 1'b1;

   // Draw sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_TOTAL,
      S_RHS,
      S_BACK_MUL,
      S_BACK_CMP,
      S_FWD_RD,
      S_FWD_MUL,
      S_FWD_CMP,
      S_DONE
   } srs_state_type;

endpackage : srs_pkg
`default_nettype wire

// File: rtl/core/srs_ram.sv
`default_nettype none
// ============================================================================
// srs_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module srs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule : srs_ram
`default_nettype wire

// File: rtl/core/stratified_resampler.sv
`default_nettype none
// ============================================================================
// stratified_resampler: stratified resampling for a particle filter
// Weights are summed into a cumulative store; each draw request returns the
// number of cumulative entries below its stratified threshold.
// ============================================================================
// Usage:
//  - Request channel (req_*): action 0 loads one weight, last_weight closes
//    the load; the next weight starts a new load. Action 1 asks for a draw.
//  - Response channel (rsp_*): one response per draw request, none per load.
//  - CSR port: register 0 at byte address 0 holds particle_count.
//  - A load request leaves the sequencer idle. A draw request runs from its
//    acceptance through S_TOTAL and S_RHS; when the search pointer carries
//    over from the previous draw, S_BACK_MUL and S_BACK_CMP check its last
//    passed entry again. Over the store's single read port, S_FWD_RD and one
//    S_FWD_MUL, S_FWD_CMP pair per store entry compared lead to S_DONE, which
//    registers the response and returns to idle, where the next request can
//    be taken. The pointer only moves forward over one draw sequence, so over
//    a full sequence the total search is bounded by the particle count.
//  - The response register decouples the two sides: a finished response may
//    wait under rsp_stall while the next request is taken, but a draw that
//    completes behind a stalled response waits until that response is taken.
//  - Reset clears the sequencer, the load and draw bookkeeping and sets
//    particle_count to 1024; the store itself needs no clearing, since only
//    entries written by the current load are read.
// ============================================================================
module stratified_resampler (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel.
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_action,
   input  wire logic [srs_pkg::WEIGHT_BITS-1:0]   req_weight,
   input  wire logic [srs_pkg::UNIFORM_BITS-1:0]  req_uniform,
   input  wire logic                              req_last_weight,
   // Response channel.
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [srs_pkg::CNT_W-1:0]         rsp_chosen_index,
   output logic                                   rsp_last_draw,
   // Configuration port.
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [srs_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [srs_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [srs_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   import srs_pkg::*;

   // ---------------------------------------------------------------------
   // Declarations
   // ---------------------------------------------------------------------
   srs_state_type     state_ff, state_in;

   logic [CNT_W-1:0]  particle_count_ff, particle_count_in;
   logic [CUM_W-1:0]  weight_total_ff, weight_total_in;
   logic [CNT_W-1:0]  load_pos_ff, load_pos_in;
   logic              load_closed_ff, load_closed_in;
   logic [CNT_W-1:0]  draw_num_ff, draw_num_in;
   logic [CNT_W-1:0]  search_ptr_ff, search_ptr_in;

   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic               last_ff, last_in;
   logic [PROD_W-1:0]  rhs_ff, rhs_in;
   logic [PART_W-1:0]  part_hi_ff, part_lo_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  rsp_index_ff, rsp_index_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_accept;
   logic              csr_write;
   logic              rsp_free;

   logic [CNT_W-1:0]  p_used;
   logic [CNT_W-1:0]  n_cur;
   logic [CNT_W-1:0]  n_minus1;
   logic [CNT_W-1:0]  m_cur;
   logic [CNT_W-1:0]  ptr_begin;
   logic [CNT_W-1:0]  ptr_dec;
   logic [CNT_W-1:0]  ptr_inc;
   logic [CUM_W-1:0]  base_total;
   logic [CNT_W-1:0]  base_pos;
   logic [CUM_W-1:0]  load_sum;

   logic [CUM_W-1:0]   mul_a;
   logic [SCALE_W-1:0] mul_b;
   logic [PROD_W-1:0]  mul_sum;
   logic               below;

   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   logic [IDX_W-1:0]  mem_rd_addr;
   logic [CUM_W-1:0]  mem_rd_data;

   // ---------------------------------------------------------------------
   // Cumulative weight store
   // ---------------------------------------------------------------------
   srs_ram #(
      .WIDTH (CUM_W),
      .DEPTH (MAX_PARTICLES)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (load_sum),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // ---------------------------------------------------------------------
   // Configuration port
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      particle_count_in = particle_count_ff;
      if (csr_write && (csr_paddr[2] == REG_PARTICLE_COUNT)) begin
         particle_count_in = csr_pwdata[CNT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_PARTICLE_COUNT) begin
         csr_prdata = CSR_DATA_W'(particle_count_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Values derived from the current bookkeeping
   // ---------------------------------------------------------------------
   always_comb begin
      // A count of zero acts as one, a count above the store size saturates.
      if (particle_count_ff == '0) begin
         p_used = CNT_W'(1);
      end else if (particle_count_ff > CNT_W'(MAX_PARTICLES)) begin
         p_used = CNT_W'(MAX_PARTICLES);
      end else begin
         p_used = particle_count_ff;
      end

      n_cur    = (load_pos_ff < p_used) ? load_pos_ff : p_used;
      n_minus1 = n_cur - CNT_W'(1);
      m_cur    = (draw_num_ff >= p_used) ? '0 : draw_num_ff;

      // The pointer carries over within a draw sequence, clamped to n.
      ptr_begin = (m_cur == '0) ? '0 : search_ptr_ff;
      if (ptr_begin > n_cur) begin
         ptr_begin = n_cur;
      end

      // A weight after a closed load starts a new load.
      base_total = load_closed_ff ? '0 : weight_total_ff;
      base_pos   = load_closed_ff ? '0 : load_pos_ff;
      load_sum   = base_total + CUM_W'(req_weight);
   end

   assign ptr_dec = search_ptr_ff - CNT_W'(1);
   assign ptr_inc = search_ptr_ff + CNT_W'(1);

   // ---------------------------------------------------------------------
   // Split multiplier: the 42-bit operand in two halves, partials registered
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      part_hi_ff <= PART_W'(mul_a[CUM_W-1:LO_W]) * PART_W'(mul_b);
      part_lo_ff <= PART_W'(mul_a[LO_W-1:0]) * PART_W'(mul_b);
   end

   assign mul_sum = {part_hi_ff, LO_W'(0)} + PROD_W'(part_lo_ff);
   assign below   = mul_sum < rhs_ff;

   // ---------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // Sequencer: next state and datapath control
   // ---------------------------------------------------------------------
   always_comb begin
      state_in        = state_ff;
      weight_total_in = weight_total_ff;
      load_pos_in     = load_pos_ff;
      load_closed_in  = load_closed_ff;
      draw_num_in     = draw_num_ff;
      search_ptr_in   = search_ptr_ff;
      thr_in          = thr_ff;
      scale_in        = scale_ff;
      n_in            = n_ff;
      last_in         = last_ff;
      rhs_in          = rhs_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_last_in     = rsp_last_ff;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = base_pos[IDX_W-1:0];
      mem_rd_addr     = n_minus1[IDX_W-1:0];
      mul_a           = mem_rd_data;
      mul_b           = scale_ff;

      // The response register empties when the receiver takes it.
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_action == ACT_LOAD) begin
                  // Append one weight; extra weights beyond the store are dropped.
                  if (base_pos < CNT_W'(MAX_PARTICLES)) begin
                     mem_wr_en       = 1'b1;
                     weight_total_in = load_sum;
                     load_pos_in     = base_pos + CNT_W'(1);
                  end else begin
                     weight_total_in = base_total;
                     load_pos_in     = base_pos;
                  end
                  load_closed_in = req_last_weight;
                  draw_num_in    = '0;
                  search_ptr_in  = '0;
               end else begin
                  // Start a draw; the store read of the total is under way.
                  thr_in        = {m_cur[IDX_W-1:0], req_uniform};
                  scale_in      = {p_used, UNIFORM_BITS'(0)};
                  n_in          = n_cur;
                  last_in       = (m_cur == n_minus1 + CNT_W'(1) - n_cur + p_used
                                   - CNT_W'(1));
                  draw_num_in   = (m_cur == p_used - CNT_W'(1)) ? '0
                                                               : m_cur + CNT_W'(1);
                  search_ptr_in = ptr_begin;
                  state_in      = S_TOTAL;
               end
            end
         end

         S_TOTAL: begin
            // Right-hand side: threshold times total (zero with an empty load).
            mul_a    = (n_ff == '0) ? '0 : mem_rd_data;
            mul_b    = SCALE_W'(thr_ff);
            state_in = S_RHS;
         end

         S_RHS: begin
            rhs_in = mul_sum;
            if (search_ptr_ff != '0) begin
               mem_rd_addr = ptr_dec[IDX_W-1:0];
               state_in    = S_BACK_MUL;
            end else begin
               state_in = S_FWD_RD;
            end
         end

         S_BACK_MUL: begin
            state_in = S_BACK_CMP;
         end

         S_BACK_CMP: begin
            // The last passed entry is no longer below: search from the start.
            if (!below) begin
               search_ptr_in = '0;
            end
            state_in = S_FWD_RD;
         end

         S_FWD_RD: begin
            if (search_ptr_ff < n_ff) begin
               mem_rd_addr = search_ptr_ff[IDX_W-1:0];
               state_in    = S_FWD_MUL;
            end else begin
               state_in = S_DONE;
            end
         end

         S_FWD_MUL: begin
            state_in = S_FWD_CMP;
         end

         S_FWD_CMP: begin
            // Advance past an entry below the threshold and fetch the next one.
            if (below) begin
               search_ptr_in = ptr_inc;
               if (ptr_inc < n_ff) begin
                  mem_rd_addr = ptr_inc[IDX_W-1:0];
                  state_in    = S_FWD_MUL;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = search_ptr_ff;
               rsp_last_in  = last_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // State register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         particle_count_ff <= PARTICLE_COUNT_RESET;
         weight_total_ff   <= '0;
         load_pos_ff       <= '0;
         load_closed_ff    <= 1'b0;
         draw_num_ff       <= '0;
         search_ptr_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         particle_count_ff <= particle_count_in;
         weight_total_ff   <= weight_total_in;
         load_pos_ff       <= load_pos_in;
         load_closed_ff    <= load_closed_in;
         draw_num_ff       <= draw_num_in;
         search_ptr_ff     <= search_ptr_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Payload registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      thr_ff       <= thr_in;
      scale_ff     <= scale_in;
      n_ff         <= n_in;
      last_ff      <= last_in;
      rhs_ff       <= rhs_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ---------------------------------------------------------------------
   // Outputs
   // ---------------------------------------------------------------------
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chosen_index = rsp_index_ff;
   assign rsp_last_draw    = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // The store is written only by a load request taken in the idle state.
   assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == S_IDLE) && req_accept && (req_action == ACT_LOAD))
      else $error("store written outside a load request");

   // During a search the pointer never passes the number of entries in use.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (search_ptr_ff <= n_ff))
      else $error("search pointer beyond the entries in use");

   // A finished draw waits while the previous response is still stalled.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && rsp_valid && rsp_stall |=> (state_ff == S_DONE))
      else $error("draw finished over a stalled response");

   // A load request restarts the draw sequence.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_action == ACT_LOAD) |=>
         (draw_num_ff == '0) && (search_ptr_ff == '0))
      else $error("load request did not restart the draw sequence");

endmodule : stratified_resampler
`default_nettype wire
